[design/usbid_pkg.sv]
// shared types, codes and reset values for the usb id pin detector
`timescale 1ns / 1ps
`default_nettype none

package usbid_pkg;

  localparam int MV_W       = 12;
  localparam int SPR_W      = 5;
  localparam int CNF_W      = 4;
  localparam int TMO_W      = 20;
  localparam int EV_W       = 4;
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  typedef logic [EV_W-1:0] event_t;
  localparam event_t EV_NONE     = 4'd0;
  localparam event_t EV_IGNORED  = 4'd1;
  localparam event_t EV_ATTACH   = 4'd2;
  localparam event_t EV_DETACH   = 4'd3;
  localparam event_t EV_BLOCKED  = 4'd4;
  localparam event_t EV_TIMEOUT  = 4'd5;
  localparam event_t EV_ENABLED  = 4'd6;
  localparam event_t EV_DISABLED = 4'd7;
  localparam event_t EV_READING  = 4'd8;

  typedef logic [KIND_W-1:0] kind_t;
  localparam kind_t KIND_SAMPLE  = 2'd0;
  localparam kind_t KIND_TICK    = 2'd1;
  localparam kind_t KIND_ENABLE  = 2'd2;
  localparam kind_t KIND_DISABLE = 2'd3;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_SPR     = 3'd0;
  localparam cfg_idx_t CFG_CONFIRM = 3'd1;
  localparam cfg_idx_t CFG_ATTACH  = 3'd2;
  localparam cfg_idx_t CFG_DETACH  = 3'd3;
  localparam cfg_idx_t CFG_TIMEOUT = 3'd4;

  localparam logic [SPR_W-1:0] SPR_RESET    = 5'd10;
  localparam logic [CNF_W-1:0] CNF_RESET    = 4'd5;
  localparam logic [MV_W-1:0]  ATTACH_RESET = 12'd110;
  localparam logic [MV_W-1:0]  DETACH_RESET = 12'd200;
  localparam logic [TMO_W-1:0] TMO_RESET    = 20'd300000;

  // controller to datapath
  typedef struct packed {
    logic take;
    logic start_div;
    logic exec;
    logic finish;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic group_done;
    logic div_done;
  } dp_sts_t;

endpackage

`default_nettype wire

[design/usbid_ctrl.sv]
// controller state machine: sequences accept, divide, evaluate and output load
`timescale 1ns / 1ps
`default_nettype none

module usbid_ctrl import usbid_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     out_stall,
  input  dp_sts_t  sts,
  output logic     in_stall,
  output logic     out_valid,
  output ctl_cmd_t cmd
);

  typedef enum logic [1:0] {S_IDLE, S_CHECK, S_DIV, S_EVAL} state_t;

  state_t state;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd      = '0;
    cmd.take = (state == S_IDLE) && in_valid;
    case (state)
      S_CHECK: begin
        if (sts.group_done) begin
          cmd.start_div = 1'b1;
        end else if (out_free) begin
          cmd.exec = 1'b1;
        end
      end
      S_EVAL: begin
        if (out_free) begin
          cmd.finish = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (sts.group_done) begin
            state <= S_DIV;
          end else if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_DIV: begin
          if (sts.div_done) begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (cmd.exec || cmd.finish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[design/usbid_datapath.sv]
// datapath: config registers, detector state, serial divider, result register
`timescale 1ns / 1ps
`default_nettype none

module usbid_datapath import usbid_pkg::*; #(
  parameter int ADC_BITS    = 12,
  parameter int MAX_SAMPLES = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ctl_cmd_t              cmd,
  output dp_sts_t               sts,
  input  logic [KIND_W-1:0]     kind,
  input  logic [MV_W-1:0]       sample_mv,
  input  logic                  vbus_present,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic [EV_W-1:0]       event_res,
  output logic [MV_W-1:0]       reading_mv,
  output logic                  host_attached,
  output logic                  pull_enable,
  output logic                  host_enabled
);

  // largest effective group size: the register tops out at 31
  localparam int NCAP  = (MAX_SAMPLES < 31) ? MAX_SAMPLES : 31;
  localparam int SUM_W = MV_W + $clog2(NCAP + 1);
  localparam int CNT_W = $clog2(SUM_W + 1);
  localparam logic [MV_W-1:0] SAMPLE_MASK =
    (ADC_BITS >= MV_W) ? {MV_W{1'b1}} : MV_W'((1 << ADC_BITS) - 1);

  // config registers
  logic [SPR_W-1:0] samples_per_reading;
  logic [CNF_W-1:0] confirm_count;
  logic [MV_W-1:0]  attach_threshold_mv;
  logic [MV_W-1:0]  detach_threshold_mv;
  logic [TMO_W-1:0] idle_timeout_ms;

  // detector state
  logic             enabled_flag, enabled_flag_next;
  logic             id_high, id_high_next;
  logic [SUM_W-1:0] sample_sum, sample_sum_next;
  logic [SPR_W-1:0] sample_index, sample_index_next;
  logic             confirming, confirming_next;
  logic [CNF_W-1:0] confirm_index, confirm_index_next;
  logic [TMO_W-1:0] timeout_left, timeout_left_next;
  logic             timeout_running, timeout_running_next;

  // latched item
  kind_t            item_kind;
  logic [MV_W-1:0]  item_sample;
  logic             item_vbus;

  // divider
  logic [SUM_W-1:0] quot;
  logic [SPR_W-1:0] rem;
  logic [CNT_W-1:0] div_cnt;
  logic [SPR_W:0]   trial;
  logic             trial_ge;

  logic [SPR_W-1:0] n_eff;
  logic [SPR_W-1:0] index_inc;
  logic [SUM_W-1:0] sum_inc;
  logic [CNF_W-1:0] cidx_inc;
  logic [MV_W-1:0]  reading;
  logic [MV_W-1:0]  thr;
  logic             level;
  logic             take_change;
  event_t           ev_next;
  logic [MV_W-1:0]  rd_next;

  always_comb begin
    if (samples_per_reading == '0) begin
      n_eff = SPR_W'(1);
    end else if (samples_per_reading > SPR_W'(NCAP)) begin
      n_eff = SPR_W'(NCAP);
    end else begin
      n_eff = samples_per_reading;
    end
  end

  assign index_inc = sample_index + SPR_W'(1);
  assign sum_inc   = sample_sum + SUM_W'(item_sample);
  assign cidx_inc  = confirm_index + CNF_W'(1);
  assign reading   = quot[MV_W-1:0];
  assign thr       = id_high ? attach_threshold_mv : detach_threshold_mv;
  assign level     = reading > thr;

  assign sts.group_done = (item_kind == KIND_SAMPLE) && enabled_flag && (index_inc >= n_eff);
  assign sts.div_done   = (div_cnt == '0);

  // one quotient bit per cycle
  assign trial    = {rem, quot[SUM_W-1]};
  assign trial_ge = trial >= {1'b0, n_eff};

  always_comb begin
    enabled_flag_next    = enabled_flag;
    id_high_next         = id_high;
    sample_sum_next      = sample_sum;
    sample_index_next    = sample_index;
    confirming_next      = confirming;
    confirm_index_next   = confirm_index;
    timeout_left_next    = timeout_left;
    timeout_running_next = timeout_running;
    ev_next              = EV_NONE;
    rd_next              = '0;
    take_change          = 1'b0;

    if (cmd.start_div) begin
      sample_sum_next   = '0;
      sample_index_next = '0;
    end

    if (cmd.exec) begin
      case (item_kind)
        KIND_SAMPLE: begin
          if (!enabled_flag) begin
            ev_next = EV_IGNORED;
          end else begin
            sample_sum_next   = sum_inc;
            sample_index_next = index_inc;
          end
        end
        KIND_TICK: begin
          if (enabled_flag && timeout_running) begin
            if (timeout_left <= TMO_W'(1)) begin
              enabled_flag_next    = 1'b0;
              timeout_running_next = 1'b0;
              timeout_left_next    = '0;
              sample_sum_next      = '0;
              sample_index_next    = '0;
              confirming_next      = 1'b0;
              confirm_index_next   = '0;
              ev_next              = EV_TIMEOUT;
            end else begin
              timeout_left_next = timeout_left - TMO_W'(1);
            end
          end
        end
        KIND_ENABLE: begin
          if (enabled_flag) begin
            ev_next = EV_IGNORED;
          end else begin
            enabled_flag_next    = 1'b1;
            id_high_next         = 1'b1;
            sample_sum_next      = '0;
            sample_index_next    = '0;
            confirming_next      = 1'b0;
            confirm_index_next   = '0;
            timeout_left_next    = idle_timeout_ms;
            timeout_running_next = 1'b1;
            ev_next              = EV_ENABLED;
          end
        end
        KIND_DISABLE: begin
          if (!enabled_flag) begin
            ev_next = EV_IGNORED;
          end else begin
            enabled_flag_next    = 1'b0;
            timeout_running_next = 1'b0;
            timeout_left_next    = '0;
            sample_sum_next      = '0;
            sample_index_next    = '0;
            confirming_next      = 1'b0;
            confirm_index_next   = '0;
            ev_next              = EV_DISABLED;
          end
        end
        default: begin
        end
      endcase
    end

    if (cmd.finish) begin
      rd_next = reading;
      ev_next = EV_READING;
      if (level == id_high) begin
        confirming_next    = 1'b0;
        confirm_index_next = '0;
      end else if (!confirming) begin
        if (confirm_count == '0) begin
          take_change = 1'b1;
        end else begin
          confirming_next    = 1'b1;
          confirm_index_next = '0;
        end
      end else if (cidx_inc >= confirm_count) begin
        take_change = 1'b1;
      end else begin
        confirm_index_next = cidx_inc;
      end

      if (take_change) begin
        confirming_next    = 1'b0;
        confirm_index_next = '0;
        if (level) begin
          id_high_next         = 1'b1;
          timeout_left_next    = idle_timeout_ms;
          timeout_running_next = 1'b1;
          ev_next              = EV_DETACH;
        end else if (item_vbus) begin
          ev_next = EV_BLOCKED;
        end else begin
          id_high_next         = 1'b0;
          timeout_running_next = 1'b0;
          timeout_left_next    = '0;
          ev_next              = EV_ATTACH;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      samples_per_reading <= SPR_RESET;
      confirm_count       <= CNF_RESET;
      attach_threshold_mv <= ATTACH_RESET;
      detach_threshold_mv <= DETACH_RESET;
      idle_timeout_ms     <= TMO_RESET;
      enabled_flag        <= 1'b0;
      id_high             <= 1'b1;
      sample_sum          <= '0;
      sample_index        <= '0;
      confirming          <= 1'b0;
      confirm_index       <= '0;
      timeout_left        <= '0;
      timeout_running     <= 1'b0;
      div_cnt             <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SPR:     samples_per_reading <= cfg_data[SPR_W-1:0];
          CFG_CONFIRM: confirm_count       <= cfg_data[CNF_W-1:0];
          CFG_ATTACH:  attach_threshold_mv <= cfg_data[MV_W-1:0];
          CFG_DETACH:  detach_threshold_mv <= cfg_data[MV_W-1:0];
          CFG_TIMEOUT: idle_timeout_ms     <= cfg_data[TMO_W-1:0];
          default: begin
          end
        endcase
      end
      enabled_flag    <= enabled_flag_next;
      id_high         <= id_high_next;
      sample_sum      <= sample_sum_next;
      sample_index    <= sample_index_next;
      confirming      <= confirming_next;
      confirm_index   <= confirm_index_next;
      timeout_left    <= timeout_left_next;
      timeout_running <= timeout_running_next;
      if (cmd.start_div) begin
        div_cnt <= CNT_W'(SUM_W);
      end else if (div_cnt != '0) begin
        div_cnt <= div_cnt - CNT_W'(1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      item_kind   <= kind;
      item_sample <= sample_mv & SAMPLE_MASK;
      item_vbus   <= vbus_present;
    end
    if (cmd.start_div) begin
      quot <= sum_inc;
      rem  <= '0;
    end else if (div_cnt != '0) begin
      quot <= {quot[SUM_W-2:0], trial_ge};
      rem  <= trial_ge ? SPR_W'(trial - {1'b0, n_eff}) : trial[SPR_W-1:0];
    end
    if (cmd.exec || cmd.finish) begin
      event_res     <= ev_next;
      reading_mv    <= rd_next;
      host_attached <= enabled_flag_next & ~id_high_next;
      pull_enable   <= enabled_flag_next;
      host_enabled  <= enabled_flag_next;
    end
  end

endmodule

`default_nettype wire

[design/usb_id_pin_otg_detector_top.sv]
// top level of the usb id pin otg host attach detector
`timescale 1ns / 1ps
`default_nettype none

// usb id pin otg detector: every accepted item (adc sample, millisecond tick,
// enable or disable) gives exactly one result item. while enabled, samples
// are summed into groups of samples_per_reading (0 acts as 1, at most
// min(MAX_SAMPLES,31)) and each group is averaged into one reading, compared
// against attach_threshold_mv while detached and detach_threshold_mv while
// attached; a level change must repeat in confirm_count further readings,
// attach is refused while vbus is present, and an idle timeout of
// idle_timeout_ms ticks switches host mode off. an item is accepted, then
// executed into the output register; a sample that closes a group first runs
// a bit-serial restoring divider, one quotient bit per cycle over SUM_W =
// 12 + clog2(min(MAX_SAMPLES,31) + 1) bits, then is evaluated. the output
// register lets the next item be accepted while a result waits.
// config writes are always ready and should only be issued while idle.
module usb_id_pin_otg_detector_top import usbid_pkg::*; #(
  parameter int ADC_BITS    = 12,
  parameter int MAX_SAMPLES = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  // input item channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [KIND_W-1:0]     kind,
  input  logic [MV_W-1:0]       sample_mv,
  input  logic                  vbus_present,
  // result item channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [EV_W-1:0]       event_res,
  output logic [MV_W-1:0]       reading_mv,
  output logic                  host_attached,
  output logic                  pull_enable,
  output logic                  host_enabled,
  // config write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  // registers take a write in any cycle
  assign cfg_ready = 1'b1;

  // sequencing: idle, check, divide, evaluate
  usbid_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // detector state, divider and result register
  usbid_datapath #(
    .ADC_BITS    (ADC_BITS),
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .kind          (kind),
    .sample_mv     (sample_mv),
    .vbus_present  (vbus_present),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .event_res     (event_res),
    .reading_mv    (reading_mv),
    .host_attached (host_attached),
    .pull_enable   (pull_enable),
    .host_enabled  (host_enabled)
  );

  // one item in flight: an accepted item holds off the next one
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("item accepted while another is in progress");

  // a cable can only be reported attached while host mode is on
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!host_attached || (host_enabled && pull_enable)))
    else $error("host attached reported while host mode off");

  // only reading-type events carry a voltage
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_res != EV_ATTACH && event_res != EV_DETACH &&
     event_res != EV_BLOCKED && event_res != EV_READING) |-> (reading_mv == '0))
    else $error("reading value on a non-reading event");

  // the divider is only started from a group-closing sample
  assert property (@(posedge clk) disable iff (rst)
    cmd.start_div |-> (sts.group_done && !cmd.exec && !cmd.finish))
    else $error("divider started without a closed sample group");

endmodule

`default_nettype wire
